>>> design/encspd_pkg.sv
// ----------------------------------------------------------------------------
// encspd_pkg: shared types and constants for the encoder speed estimator
// Field widths, register indexes, controller states and the command and
// status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package encspd_pkg;

  // Period bits actually used by the divider (8..32)
  localparam int PERIOD_WIDTH = 32;

  localparam int COUNT_W  = 16;
  localparam int EPER_W   = 32;
  localparam int POS_W    = 32;
  localparam int SPEED_W  = 21;
  localparam int THR_W    = 20;
  localparam int NUM_W    = 24;
  localparam int IN_TDATA_W  = 48;  // count 16 + period 32
  localparam int OUT_TDATA_W = 56;  // position 32 + speed 21 + forward 1, padded

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  // One quotient bit per step
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(3200);
  localparam logic [NUM_W-1:0] NUM_RESET = NUM_W'(1312500);

  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_NUMERATOR = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic capture;   // latch input word
    logic prep;      // delta, position, mode decision, divider load
    logic div_step;  // one restoring division step
    logic out_load;  // load result register and speed history
  } encspd_cmd_t;

  typedef struct packed {
    logic use_t;     // period method chosen for this word (valid in S_PREP)
    logic out_free;  // result register can take a new word
  } encspd_sts_t;

endpackage

`default_nettype wire

>>> design/encspd_ctrl.sv
// ----------------------------------------------------------------------------
// encspd_ctrl: sequencing controller
// Steps one input word through prepare, optional division and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module encspd_ctrl
  import encspd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  encspd_sts_t      sts,
  output encspd_cmd_t      cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        cnt_nxt  = '0;
        state_nxt = sts.use_t ? S_DIV : S_OUT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_prep_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PREP && sts.use_t) |=> (state_r == S_DIV))
    else $error("period method did not enter division");

  a_prep_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PREP && !sts.use_t) |=> (state_r == S_OUT))
    else $error("count method did not go straight to result");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r <= CNT_W'(DIV_STEPS - 1)))
    else $error("division step count overran");

endmodule

`default_nettype wire

>>> design/encspd_dp.sv
// ----------------------------------------------------------------------------
// encspd_dp: estimator datapath
// Config registers, position and delta, mode decision, restoring divider,
// saturation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module encspd_dp
  import encspd_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                    cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]       out_tdata,
  output logic                         out_tuser,
  input  encspd_cmd_t                  cmd,
  output encspd_sts_t                  sts
);

  // configuration
  logic [THR_W-1:0] thr_r;
  logic [NUM_W-1:0] num_r;

  // sample state
  logic [COUNT_W-1:0]        last_count_r;
  logic [POS_W-1:0]          pos_r;
  logic                      mode_r;
  logic signed [SPEED_W-1:0] last_speed_r;

  // captured word
  logic [COUNT_W-1:0]      count_r;
  logic [PERIOD_WIDTH-1:0] period_r;

  // per-word working registers
  logic             neg_r;
  logic [NUM_W-1:0] mmag_r;
  logic             use_t_r;

  // divider
  logic [PERIOD_WIDTH-1:0] rem_r;
  logic [NUM_W-1:0]        quo_r;

  // result register
  logic                      out_valid_r;
  logic [POS_W-1:0]          out_pos_r;
  logic signed [SPEED_W-1:0] out_speed_r;
  logic                      out_fwd_r;
  logic                      out_t_r;

  logic [COUNT_W-1:0]    diff;
  logic [COUNT_W:0]      absd;
  logic [NUM_W-1:0]      mprod;
  logic [SPEED_W-1:0]    prevmag;
  logic                  use_t;
  logic [PERIOD_WIDTH:0] trial;
  logic                  fits;
  logic [NUM_W-1:0]      mag_sel;
  logic signed [SPEED_W-1:0] speed_sat;

  // delta, modulo 2^16
  always_comb begin
    diff  = count_r - last_count_r;
    absd  = diff[COUNT_W-1] ? ((COUNT_W+1)'(1) << COUNT_W) - {1'b0, diff}
                            : {1'b0, diff};
    mprod = NUM_W'(absd) * NUM_W'(125);
  end

  // mode decision on the previous speed
  always_comb begin
    prevmag = last_speed_r[SPEED_W-1] ? SPEED_W'(0) - SPEED_W'(last_speed_r)
                                      : SPEED_W'(last_speed_r);
    if (!mode_r) begin
      use_t = (prevmag < SPEED_W'(thr_r)) && (period_r != '0);
    end else begin
      use_t = !((prevmag > SPEED_W'(thr_r)) || (period_r == '0));
    end
  end

  // restoring division step
  always_comb begin
    trial = {rem_r, quo_r[NUM_W-1]};
    fits  = trial >= {1'b0, period_r};
  end

  // saturation to the speed range
  always_comb begin
    mag_sel = use_t_r ? quo_r : mmag_r;
    if (neg_r) begin
      if (mag_sel > NUM_W'(1048576)) begin
        speed_sat = signed'(SPEED_W'(1) << (SPEED_W - 1));
      end else begin
        speed_sat = signed'(SPEED_W'(0) - mag_sel[SPEED_W-1:0]);
      end
    end else begin
      if (mag_sel > NUM_W'(1048575)) begin
        speed_sat = signed'({1'b0, {(SPEED_W-1){1'b1}}});
      end else begin
        speed_sat = signed'(mag_sel[SPEED_W-1:0]);
      end
    end
  end

  assign sts.use_t    = use_t;
  assign sts.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r        <= THR_RESET;
      num_r        <= NUM_RESET;
      last_count_r <= '0;
      pos_r        <= '0;
      mode_r       <= 1'b0;
      last_speed_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_SWITCH_THRESHOLD: thr_r <= cfg_data[THR_W-1:0];
          REG_PERIOD_NUMERATOR: num_r <= cfg_data[NUM_W-1:0];
          default: ;
        endcase
      end
      if (cmd.prep) begin
        last_count_r <= count_r;
        pos_r        <= pos_r + {{(POS_W-COUNT_W){diff[COUNT_W-1]}}, diff};
        mode_r       <= use_t;
      end
      if (cmd.out_load) begin
        last_speed_r <= speed_sat;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      count_r  <= in_tdata[COUNT_W-1:0];
      period_r <= in_tdata[COUNT_W +: PERIOD_WIDTH];
    end
    if (cmd.prep) begin
      neg_r   <= diff[COUNT_W-1];
      mmag_r  <= mprod >> 3;
      use_t_r <= use_t;
      rem_r   <= '0;
      quo_r   <= num_r;
    end
    if (cmd.div_step) begin
      rem_r <= fits ? PERIOD_WIDTH'(trial - {1'b0, period_r})
                    : trial[PERIOD_WIDTH-1:0];
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
    if (cmd.out_load) begin
      out_pos_r   <= pos_r;
      out_speed_r <= speed_sat;
      out_fwd_r   <= !neg_r;
      out_t_r     <= use_t_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_t_r;
  assign out_tdata  = {{(OUT_TDATA_W-POS_W-SPEED_W-1){1'b0}},
                       out_fwd_r, out_speed_r, out_pos_r};

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result overwritten before it was taken");

  a_hist: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (out_valid_r && last_speed_r == out_speed_r))
    else $error("speed history disagrees with delivered speed");

endmodule

`default_nettype wire

>>> design/encoder_mt_speed_estimator_top.sv
// ----------------------------------------------------------------------------
// encoder_mt_speed_estimator_top: quadrature encoder M/T speed estimator
// Tracks a wrapping 32-bit position from a 16-bit counter and estimates
// speed in 1/256 rps by pulse count or by edge period.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake              word contents (lsb first)
//  in_      in   in_tvalid/in_tready    count_reading[15:0], edge_period[47:16]
//  out_     out  out_tvalid/out_tready  position[31:0], speed[52:32],
//                                       forward[53], pad; tuser = period method
//  cfg_     in   cfg_valid/cfg_ready    cfg_index 0 threshold, 1 numerator
//
// One word at a time. Count method: the word is captured, prepared and its
// result loaded; period method: after the prepare step the result waits for
// the 24-step restoring divider (one quotient bit per cycle) before the load.
// Next word is accepted the cycle after load.
// A finished result sits in the output register while the next word is
// taken; the result load stalls only if that register is still full.
// Synchronous active-low reset; config writes always accepted (cfg_ready=1).
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_mt_speed_estimator_top
  import encspd_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // count_reading[15:0], edge_period[47:16]
  input  wire logic [IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  // position[31:0], speed[52:32], forward[53], zeros[55:54]
  output logic [OUT_TDATA_W-1:0]       out_tdata,
  // using_period_method
  output logic                         out_tuser,
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

  encspd_cmd_t cmd;
  encspd_sts_t sts;

  assign cfg_ready = 1'b1;

  encspd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  encspd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

`default_nettype wire
